/* hdl/conv2d_replicate_border_macros.svh */
// Assertion macros shared by the convolution block.
`ifndef CONV2D_REPLICATE_BORDER_MACROS_SVH
`define CONV2D_REPLICATE_BORDER_MACROS_SVH

// Checked while out of reset.
`define C2RB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define C2RB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/c2rb_pkg.sv */
// Types and constants shared by the convolution block.
package c2rb_pkg;

  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int MAX_KERNEL_DEF = 7;

  localparam int DATA_W    = 16;
  localparam int SUM_W     = 32;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int KSIZE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;

  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_COEF    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 2'd2;

  localparam logic [DIM_W-1:0]   HEIGHT_RST = 9'd256;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 9'd256;
  localparam logic [KSIZE_W-1:0] KSIZE_RST  = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMPTY
  } seq_state_t;

  // sequencer to multiply-accumulate pipe
  typedef struct packed {
    logic clear;
    logic issue;
    logic last;
  } mac_ctl_t;

  // result that needs no accumulation (outside image or empty window)
  typedef struct packed {
    logic emit;
    logic status;
  } rslt_ctl_t;

endpackage

/* hdl/c2rb_ram.sv */
// Generic single-port RAM with registered read.
module c2rb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/c2rb_mac.sv */
// Multiply-accumulate pipe over the words read from both stores.
module c2rb_mac import c2rb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] img_rdata,
  input  logic signed [DATA_W-1:0] ker_rdata,
  output logic                     sum_valid,
  output logic        [SUM_W-1:0]  sum
);

  logic                    v1, l1, v2, l2;
  logic signed [SUM_W-1:0] prod;
  logic        [SUM_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      l1 <= 1'b0;
      v2 <= 1'b0;
      l2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      l1 <= ctl.issue & ctl.last;
      v2 <= v1;
      l2 <= l1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= SUM_W'(img_rdata) * SUM_W'(ker_rdata);
    if (ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  assign sum       = acc + prod;
  assign sum_valid = v2 & l2;

endmodule

/* hdl/c2rb_seq.sv */
// Command decode and window address sequencer with border clamping.
module c2rb_seq import c2rb_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS,
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL,
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1,
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           op,
  input  logic [COORD_W-1:0]   row,
  input  logic [COORD_W-1:0]   col,
  input  logic [DIM_W-1:0]     image_height,
  input  logic [DIM_W-1:0]     image_width,
  input  logic [KSIZE_W-1:0]   kernel_size,
  input  logic                 sum_valid,
  output logic                 busy,
  output logic                 img_we,
  output logic [IMG_AW-1:0]    img_addr,
  output logic                 ker_we,
  output logic [KER_AW-1:0]    ker_addr,
  output mac_ctl_t             ctl,
  output rslt_ctl_t            rslt,
  output logic [COORD_W-1:0]   row_s,
  output logic [COORD_W-1:0]   col_s
);

  localparam int DMAX0  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DMAX   = (DMAX0 > 512) ? DMAX0 : 512;
  localparam int SW     = $clog2(DMAX + 2 * MAX_KERNEL) + 1;
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  seq_state_t state, state_next;

  logic [KSIZE_W-1:0]   p, q, k_s;
  logic                 status_s;
  logic signed [SW-1:0] hmax, wmax;

  logic                 accept, cmp_acc, last;
  logic [KSIZE_W-1:0]   k_eff, half;
  logic [SW-1:0]        hv, wv;
  logic signed [SW-1:0] hmax_next, wmax_next;
  logic                 outside;
  logic signed [SW-1:0] x_raw, y_raw, x_cl, y_cl;
  logic [RIDX_W-1:0]    x_idx;
  logic [CIDX_W-1:0]    y_idx;
  logic [IMG_AW-1:0]    rd_addr, wr_addr;

  assign accept  = start & (state == ST_IDLE);
  assign cmp_acc = accept & (op == OP_COMPUTE);

  // effective dimensions: zero means one, oversize saturates
  always_comb begin
    hv = SW'(image_height);
    wv = SW'(image_width);
    if (hv == '0) begin
      hmax_next = '0;
    end else if (hv > SW'(MAX_ROWS)) begin
      hmax_next = SW'(MAX_ROWS - 1);
    end else begin
      hmax_next = hv - SW'(1);
    end
    if (wv == '0) begin
      wmax_next = '0;
    end else if (wv > SW'(MAX_COLS)) begin
      wmax_next = SW'(MAX_COLS - 1);
    end else begin
      wmax_next = wv - SW'(1);
    end
    if ({1'b0, kernel_size} > 4'(MAX_KERNEL)) begin
      k_eff = KSIZE_W'(MAX_KERNEL);
    end else begin
      k_eff = kernel_size;
    end
    outside = ($signed(SW'(row)) > hmax_next) | ($signed(SW'(col)) > wmax_next);
  end

  // window tap address, clamped into the image
  always_comb begin
    half  = k_s >> 1;
    x_raw = $signed(SW'(row_s)) - $signed(SW'(half)) + $signed(SW'(p));
    y_raw = $signed(SW'(col_s)) - $signed(SW'(half)) + $signed(SW'(q));
    if (x_raw < 0) begin
      x_cl = '0;
    end else if (x_raw > hmax) begin
      x_cl = hmax;
    end else begin
      x_cl = x_raw;
    end
    if (y_raw < 0) begin
      y_cl = '0;
    end else if (y_raw > wmax) begin
      y_cl = wmax;
    end else begin
      y_cl = y_raw;
    end
    x_idx   = x_cl[RIDX_W-1:0];
    y_idx   = y_cl[CIDX_W-1:0];
    rd_addr = IMG_AW'(x_idx) * IMG_AW'(MAX_COLS) + IMG_AW'(y_idx);
    wr_addr = IMG_AW'(row) * IMG_AW'(MAX_COLS) + IMG_AW'(col);
    last    = (p == k_s - KSIZE_W'(1)) & (q == k_s - KSIZE_W'(1));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmp_acc) begin
          state_next = (outside | (k_eff == '0)) ? ST_EMPTY : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sum_valid) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    img_we      = accept & (op == OP_PIXEL) & (SW'(row) < SW'(MAX_ROWS)) &
                  (SW'(col) < SW'(MAX_COLS));
    ker_we      = accept & (op == OP_COEF) & (row < COORD_W'(MAX_KERNEL)) &
                  (col < COORD_W'(MAX_KERNEL));
    img_addr    = (state == ST_IDLE) ? wr_addr : rd_addr;
    ker_addr    = (state == ST_IDLE) ?
                  KER_AW'(row) * KER_AW'(MAX_KERNEL) + KER_AW'(col) :
                  KER_AW'(p) * KER_AW'(MAX_KERNEL) + KER_AW'(q);
    ctl.clear   = cmp_acc;
    ctl.issue   = (state == ST_RUN);
    ctl.last    = last;
    rslt.emit   = (state == ST_EMPTY);
    rslt.status = status_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p     <= '0;
      q     <= '0;
    end else begin
      state <= state_next;
      if (cmp_acc) begin
        p <= '0;
        q <= '0;
      end else if (state == ST_RUN) begin
        if (q == k_s - KSIZE_W'(1)) begin
          q <= '0;
          p <= p + KSIZE_W'(1);
        end else begin
          q <= q + KSIZE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_acc) begin
      row_s    <= row;
      col_s    <= col;
      hmax     <= hmax_next;
      wmax     <= wmax_next;
      k_s      <= k_eff;
      status_s <= outside;
    end
  end

endmodule

/* hdl/conv2d_replicate_border.sv */
// Compute word: one image and one kernel read per cycle from single-port RAMs
// during the window scan; the next word can be accepted while done is high.
// Write words leave busy low; a request outside the image or with K = 0 skips the scan.
// done is high for one cycle with its result; the receiver cannot stall.
// rst (synchronous) restores 256 x 256 and K = 3; the stores keep their contents.
module conv2d_replicate_border import c2rb_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op,
  input  logic [COORD_W-1:0]       row,
  input  logic [COORD_W-1:0]       col,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic                     done,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic signed [SUM_W-1:0]  filtered,
  output logic                     status
);

  `include "conv2d_replicate_border_macros.svh"

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

  logic [DIM_W-1:0]   image_height, image_width;
  logic [KSIZE_W-1:0] kernel_size;

  logic               img_we, ker_we, sum_valid;
  logic [IMG_AW-1:0]  img_addr;
  logic [KER_AW-1:0]  ker_addr;
  logic [DATA_W-1:0]  img_rdata, ker_rdata;
  logic [SUM_W-1:0]   sum;
  logic [COORD_W-1:0] row_s, col_s;
  mac_ctl_t           ctl;
  rslt_ctl_t          rslt;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= HEIGHT_RST;
      image_width  <= WIDTH_RST;
      kernel_size  <= KSIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HEIGHT: image_height <= cfg_wdata;
        REG_WIDTH:  image_width  <= cfg_wdata;
        REG_KSIZE:  kernel_size  <= cfg_wdata[KSIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  c2rb_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .row          (row),
    .col          (col),
    .image_height (image_height),
    .image_width  (image_width),
    .kernel_size  (kernel_size),
    .sum_valid    (sum_valid),
    .busy         (busy),
    .img_we       (img_we),
    .img_addr     (img_addr),
    .ker_we       (ker_we),
    .ker_addr     (ker_addr),
    .ctl          (ctl),
    .rslt         (rslt),
    .row_s        (row_s),
    .col_s        (col_s)
  );

  c2rb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .addr  (img_addr),
    .wdata (value),
    .rdata (img_rdata)
  );

  c2rb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (KER_DEPTH)
  ) u_ker_ram (
    .clk   (clk),
    .we    (ker_we),
    .addr  (ker_addr),
    .wdata (value),
    .rdata (ker_rdata)
  );

  c2rb_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .img_rdata (img_rdata),
    .ker_rdata (ker_rdata),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_valid | rslt.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      filtered <= sum;
      status   <= 1'b0;
      out_row  <= row_s;
      out_col  <= col_s;
    end else if (rslt.emit) begin
      filtered <= '0;
      status   <= rslt.status;
      out_row  <= row_s;
      out_col  <= col_s;
    end
  end

  `C2RB_ASSERT(a_compute_goes_busy, clk, rst, start && !busy && op == OP_COMPUTE |=> busy, "compute word accepted but block not busy")
  `C2RB_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "result strobe without a compute in flight")
  `C2RB_ASSERT(a_fault_zero_sum, clk, rst, done && status |-> filtered == '0, "out-of-image result carries a nonzero sum")
  `C2RB_ASSERT_ALWAYS(a_no_write_while_busy, clk, busy |-> !(img_we || ker_we), "store written during a window scan")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the replicated-border 2D convolution block.
`timescale 1ns / 100ps

module testbench;
  import c2rb_pkg::*;

  localparam int ROWS = MAX_ROWS_DEF;
  localparam int COLS = MAX_COLS_DEF;
  localparam int KMAX = MAX_KERNEL_DEF;
  localparam logic [1:0] OP_NOP = 2'd3;                 // unused opcode, dropped by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;    // unmapped register index
  localparam int DRAIN_CYCLES = KMAX * KMAX + 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 180;
  localparam int NUM_SETTINGS = 8;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  value;
  } conv_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SUM_W-1:0]   filtered;
    logic               status;
  } pixel_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               op = OP_PIXEL;
  logic [COORD_W-1:0]       row = '0;
  logic [COORD_W-1:0]       col = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_addr = REG_HEIGHT;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     done;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic signed [SUM_W-1:0]  filtered;
  logic                     status;

  conv2d_replicate_border uut (.*);

  // shadow of the block: stores and registers
  logic [DATA_W-1:0]  pix_mem [ROWS*COLS];
  logic [DATA_W-1:0]  coef_mem [KMAX*KMAX];
  logic [DIM_W-1:0]   height_reg = HEIGHT_RST;
  logic [DIM_W-1:0]   width_reg = WIDTH_RST;
  logic [KSIZE_W-1:0] ksize_reg = KSIZE_RST;

  // entries already written by queued words; computes never touch anything else
  bit pix_seen [ROWS*COLS];
  bit coef_seen [KMAX*KMAX];

  conv_word_t    word_q[$];
  pixel_result_t expected_pixels[$];

  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int flagged = 0;
  int settings = 0;
  int cycles = 0;
  int gap_left = 0;
  bit calm = 1'b0;
  conv_word_t    nxt;
  pixel_result_t want;

  logic [CFG_W-1:0] set_h [NUM_SETTINGS] = '{256, 0, 511, 7, 5, 200, 1, 256};
  logic [CFG_W-1:0] set_w [NUM_SETTINGS] = '{256, 300, 1, 9, 5, 37, 1, 256};
  logic [CFG_W-1:0] set_k [NUM_SETTINGS] = '{7, 5, 4, 0, 1, 6, 2, 3};

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded the cycle limit", $time);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic int clamp_idx(int v, int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic pixel_result_t convolve_at(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    pixel_result_t res;
    logic [SUM_W-1:0] acc;
    int h, w, k, x, y, p, q, a, b;
    h = eff_dim(height_reg, ROWS);
    w = eff_dim(width_reg, COLS);
    k = ksize_reg;
    acc = '0;
    res.row = r;
    res.col = c;
    res.status = 1'b0;
    if (int'(r) >= h || int'(c) >= w) begin
      res.status = 1'b1;
    end else begin
      for (p = 0; p < k; p++) begin
        x = clamp_idx(int'(r) - k / 2 + p, h - 1);
        for (q = 0; q < k; q++) begin
          y = clamp_idx(int'(c) - k / 2 + q, w - 1);
          a = $signed(pix_mem[x*COLS + y]);
          b = $signed(coef_mem[p*KMAX + q]);
          acc += a * b;  // wraps to 32 bits
        end
      end
    end
    res.filtered = acc;
    return res;
  endfunction

  task automatic apply_word(conv_word_t wd);
    pixel_result_t res;
    case (wd.op)
      OP_PIXEL: pix_mem[int'(wd.row)*COLS + int'(wd.col)] = wd.value;
      OP_COEF: begin
        if (wd.row < KMAX && wd.col < KMAX) coef_mem[int'(wd.row)*KMAX + int'(wd.col)] = wd.value;
      end
      OP_COMPUTE: begin
        res = convolve_at(wd.row, wd.col);
        if (res.status) flagged++;
        expected_pixels.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0, 1: return 16'h8000;
      2, 3: return 16'h7FFF;
      4: return 16'h0000;
      5: return 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_word(logic [1:0] o, int r, int c, logic [DATA_W-1:0] v);
    word_q.push_back('{o, COORD_W'(r), COORD_W'(c), v});
    if (o == OP_PIXEL) pix_seen[r*COLS + c] = 1'b1;
    if (o == OP_COEF && r < KMAX && c < KMAX) coef_seen[r*KMAX + c] = 1'b1;
  endtask

  // queues writes for any window entry not yet written, then the request
  task automatic push_compute(int r, int c);
    int h, w, k, x, y, p, q;
    h = eff_dim(height_reg, ROWS);
    w = eff_dim(width_reg, COLS);
    k = ksize_reg;
    if (r < h && c < w) begin
      for (p = 0; p < k; p++) begin
        x = clamp_idx(r - k / 2 + p, h - 1);
        for (q = 0; q < k; q++) begin
          y = clamp_idx(c - k / 2 + q, w - 1);
          if (!pix_seen[x*COLS + y]) push_word(OP_PIXEL, x, y, rand_value());
          if (!coef_seen[p*KMAX + q]) push_word(OP_COEF, p, q, rand_value());
        end
      end
    end
    push_word(OP_COMPUTE, r, c, rand_value());
  endtask

  task automatic load_kernel();
    int p, q;
    for (p = 0; p < KMAX; p++)
      for (q = 0; q < KMAX; q++)
        push_word(OP_COEF, p, q, rand_value());
  endtask

  function automatic int pick_coord(int center, int dim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return clamp_idx(center + $urandom_range(0, 6) - 3, dim - 1);
    if (r < 8) return (r == 6) ? 0 : dim - 1;
    return $urandom_range(0, 255);  // may land outside the image
  endfunction

  task automatic random_phase(int n);
    int h, w, hr, hc, sel;
    h = eff_dim(height_reg, ROWS);
    w = eff_dim(width_reg, COLS);
    hr = $urandom_range(0, h - 1);
    hc = $urandom_range(0, w - 1);
    while (word_q.size() < n) begin
      if ($urandom_range(0, 29) == 0) begin
        hr = $urandom_range(0, h - 1);
        hc = $urandom_range(0, w - 1);
      end
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        push_compute(pick_coord(hr, h), pick_coord(hc, w));
      end else if (sel < 75) begin
        push_word(OP_PIXEL, pick_coord(hr, h), pick_coord(hc, w), rand_value());
      end else if (sel < 95) begin
        if ($urandom_range(0, 6) == 0)
          push_word(OP_COEF, $urandom_range(0, 255), $urandom_range(0, 255), rand_value());
        else
          push_word(OP_COEF, $urandom_range(0, KMAX-1), $urandom_range(0, KMAX-1), rand_value());
      end else begin
        push_word(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255), rand_value());
      end
    end
  endtask

  // waits until every word is in, every result out and the block has gone quiet
  task automatic settle();
    while (word_q.size() != 0 || start) @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w, logic [CFG_W-1:0] kd);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] dat [4];
    int i;
    idx = '{REG_HEIGHT, REG_WIDTH, REG_KSIZE, REG_SPARE};
    dat = '{h, w, kd, CFG_W'($urandom)};
    for (i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= dat[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    height_reg = h;
    width_reg = w;
    ksize_reg = kd[KSIZE_W-1:0];
    settings++;
  endtask

  // driver: one word on the bus at a time, random gaps between words
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        apply_word('{op, row, col, value});
        accepted++;
        if ($urandom_range(0, 63) == 0) calm = !calm;
        gap_left = calm ? 0 : pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q.size() > 0) begin
          nxt = word_q.pop_front();
          op <= nxt.op;
          row <= nxt.row;
          col <= nxt.col;
          value <= nxt.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string field, logic [SUM_W-1:0] exp_v,
                                          logic [SUM_W-1:0] got_v);
    errors++;
    $display("%0t: %s mismatch at (%0d,%0d): expected %0h, got %0h",
             $time, field, want.row, want.col, exp_v, got_v);
  endfunction

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result at (%0d,%0d): expected none, got %0h",
                 $time, out_row, out_col, filtered);
      end else begin
        want = expected_pixels.pop_front();
        checked++;
        if (out_row !== want.row) report_mismatch("out_row", want.row, out_row);
        if (out_col !== want.col) report_mismatch("out_col", want.col, out_col);
        if (filtered !== want.filtered) report_mismatch("filtered", want.filtered, filtered);
        if (status !== want.status) report_mismatch("status", want.status, status);
      end
    end
  end

  initial begin
    int i, p, q, h, w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 256 x 256, 3 x 3 kernel
    load_kernel();
    push_word(OP_COEF, 0, 0, 16'h8000);
    push_word(OP_COEF, KMAX-1, KMAX-1, 16'h7FFF);
    push_word(OP_COEF, KMAX, 0, rand_value());
    push_word(OP_COEF, 0, KMAX, rand_value());
    push_word(OP_COEF, 255, 255, rand_value());
    push_word(OP_NOP, 255, 255, 16'hFFFF);
    push_word(OP_NOP, 0, 0, 16'h0000);
    push_word(OP_PIXEL, 0, 0, 16'h8000);
    push_word(OP_PIXEL, 255, 255, 16'h7FFF);
    push_word(OP_PIXEL, 0, 255, 16'h0000);
    push_word(OP_PIXEL, 255, 0, 16'hFFFF);
    push_compute(0, 0);
    push_compute(255, 255);
    push_compute(0, 255);
    push_compute(255, 0);
    push_compute(128, 77);
    random_phase(PHASE_WORDS);
    settle();

    for (i = 0; i < NUM_SETTINGS; i++) begin
      // random upper bits on the kernel size word; only the low bits count
      write_regs(set_h[i], set_w[i], {6'($urandom), set_k[i][KSIZE_W-1:0]});
      h = eff_dim(height_reg, ROWS);
      w = eff_dim(width_reg, COLS);
      case (i)
        0: begin
          // all-negative-extreme window: 49 products of 2^30 wrap around
          for (p = 0; p < KMAX; p++)
            for (q = 0; q < KMAX; q++) begin
              push_word(OP_COEF, p, q, 16'h8000);
              push_word(OP_PIXEL, p, q, 16'h8000);
            end
          push_compute(3, 3);
          push_compute(0, 0);
          load_kernel();
        end
        1: begin
          push_compute(1, 0);
          push_compute(0, 128);
        end
        3: begin
          push_compute(7, 0);
          push_compute(0, 9);
          push_compute(255, 255);
        end
        default: ;
      endcase
      push_compute(0, 0);
      push_compute(h - 1, w - 1);
      random_phase(PHASE_WORDS);
      settle();
    end

    $display("Run covered %0d words and %0d checked results (%0d outside the image)",
             accepted, checked, flagged);
    $display("across %0d register settings beyond the reset geometry", settings);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/c2rb_pkg.sv
hdl/c2rb_ram.sv
hdl/c2rb_mac.sv
hdl/c2rb_seq.sv
hdl/conv2d_replicate_border.sv
tb/testbench.sv
